// ===== rtl/ps2khl_pkg.sv =====
// Shared types, constants and helpers for the PS/2 keyboard host link.
// No dependencies; used by ps2_keyboard_host_link and its testbench.
package ps2khl_pkg;

  // Command queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QIdxW      = (QueueDepth > 2) ? $clog2(QueueDepth) : 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_BREAK_PREFIX    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_EXTENDED_PREFIX = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES     = 2'd2;

  // Register reset values
  localparam logic [7:0] BREAK_PREFIX_RST    = 8'hF0;
  localparam logic [7:0] EXTENDED_PREFIX_RST = 8'hE0;
  localparam logic [3:0] MAX_RETRIES_RST     = 4'd5;

  // Device byte codes
  localparam logic [7:0] BYTE_ACK       = 8'hFA;
  localparam logic [7:0] BYTE_RESEND    = 8'hFE;
  localparam logic [7:0] BYTE_BAT_OK    = 8'hAA;
  localparam logic [7:0] BYTE_BAT_FAIL0 = 8'hFD;
  localparam logic [7:0] BYTE_BAT_FAIL1 = 8'hFC;
  localparam logic [7:0] BYTE_ECHO      = 8'hEE;
  localparam logic [7:0] BYTE_ERROR     = 8'hFF;
  localparam logic [7:0] BYTE_OVERRUN   = 8'h00;

  // Input kind carried in tuser
  localparam logic KIND_HOST_CMD   = 1'b0;
  localparam logic KIND_DEVICE_RX  = 1'b1;

  localparam int unsigned OutDataW = 24;

  // Queue position: wrap phase above the entry index
  typedef struct packed {
    logic             phase;
    logic [QIdxW-1:0] idx;
  } qpos_t;

  // Result beat; the last member, send_valid, sits in the lowest bits
  typedef struct packed {
    logic       retry_abandoned;
    logic       queue_full_drop;
    logic       key_make;
    logic       key_extended;
    logic [7:0] key_scancode;
    logic       key_valid;
    logic [7:0] send_byte;
    logic       send_valid;
  } result_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_HEAD_READ
  } state_e;

  function automatic qpos_t qpos_next(qpos_t p);
    qpos_t n;
    if (p.idx == QIdxW'(QueueDepth - 1)) begin
      n.idx   = '0;
      n.phase = ~p.phase;
    end else begin
      n.idx   = p.idx + QIdxW'(1);
      n.phase = p.phase;
    end
    return n;
  endfunction

endpackage

// ===== rtl/ps2khl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ps2khl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 2) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ps2_keyboard_host_link.sv =====
// PS/2 keyboard host link: command queue with ACK/RESEND handling and
// break/extended prefix tracking. Uses ps2khl_pkg and ps2khl_ram.
// Results are registered; an ACK or RESEND with a head command to send is parked until
// the command RAM read returns the head byte, then leaves from ST_HEAD_READ.
// Throughput: one beat per cycle while m_axis_tready allows; none is taken in ST_HEAD_READ.
// Reset (rst_ni low, async) empties the queue, clears retry/prefix state, reloads registers.
module ps2_keyboard_host_link (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] kind: 0 host command, 1 device byte
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] send_valid, [8:1] send_byte, [9] key_valid, [17:10] key_scancode,
  // [18] key_extended, [19] key_make, [20] queue_full_drop,
  // [21] retry_abandoned, [23:22] zero
  output logic [ps2khl_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ps2khl_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ps2khl_pkg::CfgDataW-1:0]     cfg_data_i
);

  import ps2khl_pkg::*;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e     state_q, state_d;
  qpos_t      rd_pos_q, rd_pos_d;
  qpos_t      wr_pos_q, wr_pos_d;
  logic [3:0] retry_q, retry_d;
  logic       rel_pend_q, rel_pend_d;
  logic       ext_pend_q, ext_pend_d;

  logic [7:0] break_prefix_q;
  logic [7:0] ext_prefix_q;
  logic [3:0] max_retries_q;

  // Output register and the result parked while the head is read
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  result_t    park_q, park_d;

  // ---------------------------------------------------------------------
  // Beat decode
  // ---------------------------------------------------------------------
  logic       in_fire;
  logic       q_empty, q_full;
  logic [7:0] rx_byte;
  result_t    res;
  logic       need_head;
  logic       ram_we;

  assign rx_byte = s_axis_tdata;
  assign q_empty = (rd_pos_q == wr_pos_q);
  assign q_full  = (rd_pos_q.idx == wr_pos_q.idx) && (rd_pos_q.phase != wr_pos_q.phase);

  // Accept only in ST_IDLE, and when the output register is free or drains this cycle
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Compute the queue, retry and prefix updates for one beat
  always_comb begin
    rd_pos_d   = rd_pos_q;
    wr_pos_d   = wr_pos_q;
    retry_d    = retry_q;
    rel_pend_d = rel_pend_q;
    ext_pend_d = ext_pend_q;
    res        = '0;
    need_head  = 1'b0;
    ram_we     = 1'b0;

    if (in_fire) begin
      if (s_axis_tuser == KIND_HOST_CMD) begin
        if (q_full) begin
          res.queue_full_drop = 1'b1;
        end else begin
          ram_we   = 1'b1;
          wr_pos_d = qpos_next(wr_pos_q);
          // Empty queue: send straight from the beat, no RAM read
          if (q_empty) begin
            res.send_valid = 1'b1;
            res.send_byte  = rx_byte;
          end
        end
      end else begin
        unique case (rx_byte) inside
          BYTE_OVERRUN, BYTE_ERROR, BYTE_BAT_OK, BYTE_BAT_FAIL0, BYTE_BAT_FAIL1,
          BYTE_ECHO: begin
            // status bytes: drop
          end
          BYTE_ACK: begin
            if (!q_empty) begin
              rd_pos_d = qpos_next(rd_pos_q);
            end
            retry_d   = '0;
            need_head = (rd_pos_d != wr_pos_q);
          end
          BYTE_RESEND: begin
            if (retry_q >= max_retries_q) begin
              if (!q_empty) begin
                rd_pos_d            = qpos_next(rd_pos_q);
                res.retry_abandoned = 1'b1;
              end
              retry_d = '0;
            end else begin
              retry_d = retry_q + 4'd1;
            end
            need_head = (rd_pos_d != wr_pos_q);
          end
          default: begin
            // Break wins over extended when both prefixes match
            if (rx_byte == break_prefix_q) begin
              rel_pend_d = 1'b1;
            end else if (rx_byte == ext_prefix_q) begin
              ext_pend_d = 1'b1;
            end else begin
              res.key_valid    = 1'b1;
              res.key_scancode = rx_byte;
              res.key_extended = ext_pend_q;
              res.key_make     = ~rel_pend_q;
              rel_pend_d       = 1'b0;
              ext_pend_d       = 1'b0;
            end
          end
        endcase
        res.send_valid = need_head;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Command store
  // ---------------------------------------------------------------------
  logic [7:0] head_byte;

  ps2khl_ram #(
    .Width (8),
    .Depth (QueueDepth)
  ) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos_q.idx),
    .wdata_i (rx_byte),
    .re_i    (need_head),
    .raddr_i (rd_pos_d.idx),
    .rdata_o (head_byte)
  );

  // ---------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && need_head) begin
          state_d = ST_HEAD_READ;
        end
      end
      ST_HEAD_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register loading
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    park_d      = park_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (need_head) begin
            // hold the result until the head byte arrives
            park_d = res;
          end else begin
            out_d       = res;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_HEAD_READ: begin
        out_d           = park_q;
        out_d.send_byte = head_byte;
        out_valid_d     = 1'b1;
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      retry_q     <= '0;
      rel_pend_q  <= 1'b0;
      ext_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      retry_q     <= retry_d;
      rel_pend_q  <= rel_pend_d;
      ext_pend_q  <= ext_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    park_q <= park_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_prefix_q <= BREAK_PREFIX_RST;
      ext_prefix_q   <= EXTENDED_PREFIX_RST;
      max_retries_q  <= MAX_RETRIES_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BREAK_PREFIX:    break_prefix_q <= cfg_data_i;
        REG_EXTENDED_PREFIX: ext_prefix_q   <= cfg_data_i;
        REG_MAX_RETRIES:     max_retries_q  <= cfg_data_i[3:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ps2_keyboard_host_link: directed cases, then mixed random traffic.
// Checks every result beat against a built-in model of the link.
// Depends on ps2khl_pkg and the ps2_keyboard_host_link RTL.
`timescale 1ns / 1ps

module testbench;
  import ps2khl_pkg::*;

  // Unused register slot; writes to it must not change anything
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int StallLimit = 2000;
  localparam int ReportLimit = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tuser = KIND_HOST_CMD;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = REG_BREAK_PREFIX;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ps2_keyboard_host_link i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Link model: its own copy of the command queue, retry count, prefix flags and
  // registers. Reset is applied once, so the declarations hold the reset state.
  // ---------------------------------------------------------------------------
  logic [7:0] host_cmd_queue[$];        // commands waiting for ACK, head first
  logic [3:0] resend_count     = '0;
  logic       release_seen     = 1'b0;
  logic       extended_seen    = 1'b0;
  logic [7:0] brk_code         = BREAK_PREFIX_RST;
  logic [7:0] ext_code         = EXTENDED_PREFIX_RST;
  logic [3:0] retry_limit      = MAX_RETRIES_RST;

  result_t    results_due[$];           // predicted beats, oldest first

  int src_idle_pct  = 0;                // chance per cycle that the sender holds off
  int sink_stall_pct = 0;               // chance per cycle that the receiver stalls
  int idle_cycles   = 0;                // cycles in a row with no beat anywhere
  int error_count   = 0;
  int beats_checked = 0;
  int key_reports   = 0;
  int bytes_to_kbd  = 0;
  int refused_cmds  = 0;
  int dropped_cmds  = 0;
  int reg_writes    = 0;

  function automatic bit is_status(logic [7:0] b);
    return b inside {BYTE_OVERRUN, BYTE_ERROR, BYTE_BAT_OK, BYTE_BAT_FAIL0,
                     BYTE_BAT_FAIL1, BYTE_ECHO};
  endfunction

  // Advance the model by one input beat and return the beat it must produce.
  function automatic result_t predict_link_beat(logic kind, logic [7:0] b);
    result_t r;
    r = '0;
    if (kind == KIND_HOST_CMD) begin
      if (host_cmd_queue.size() == QueueDepth) begin
        r.queue_full_drop = 1'b1;
      end else begin
        // An empty queue means the line is free: transmit right away
        if (host_cmd_queue.size() == 0) begin
          r.send_valid = 1'b1;
          r.send_byte  = b;
        end
        host_cmd_queue.push_back(b);
      end
    end else if (is_status(b)) begin
      // status bytes leave all state alone, pending prefixes included
    end else if (b == BYTE_ACK) begin
      if (host_cmd_queue.size() != 0) void'(host_cmd_queue.pop_front());
      resend_count = '0;
      if (host_cmd_queue.size() != 0) begin
        r.send_valid = 1'b1;
        r.send_byte  = host_cmd_queue[0];
      end
    end else if (b == BYTE_RESEND) begin
      // At the limit drop the head; with an empty queue only the count resets
      if (resend_count >= retry_limit) begin
        if (host_cmd_queue.size() != 0) begin
          void'(host_cmd_queue.pop_front());
          r.retry_abandoned = 1'b1;
        end
        resend_count = '0;
      end else begin
        resend_count = resend_count + 4'd1;
      end
      if (host_cmd_queue.size() != 0) begin
        r.send_valid = 1'b1;
        r.send_byte  = host_cmd_queue[0];
      end
    end else if (b == brk_code) begin
      // break wins when both prefixes hold the same byte
      release_seen = 1'b1;
    end else if (b == ext_code) begin
      extended_seen = 1'b1;
    end else begin
      r.key_valid    = 1'b1;
      r.key_scancode = b;
      r.key_extended = extended_seen;
      r.key_make     = ~release_seen;
      release_seen   = 1'b0;
      extended_seen  = 1'b0;
    end
    return r;
  endfunction

  function automatic string field_diffs(logic [OutDataW-1:0] beat, result_t want);
    result_t got;
    string   s;
    got = result_t'(beat[$bits(result_t)-1:0]);
    s = "";
    if (got.send_valid      !== want.send_valid)      s = {s, " send_valid"};
    if (got.send_byte       !== want.send_byte)       s = {s, " send_byte"};
    if (got.key_valid       !== want.key_valid)       s = {s, " key_valid"};
    if (got.key_scancode    !== want.key_scancode)    s = {s, " key_scancode"};
    if (got.key_extended    !== want.key_extended)    s = {s, " key_extended"};
    if (got.key_make        !== want.key_make)        s = {s, " key_make"};
    if (got.queue_full_drop !== want.queue_full_drop) s = {s, " queue_full_drop"};
    if (got.retry_abandoned !== want.retry_abandoned) s = {s, " retry_abandoned"};
    if (beat[OutDataW-1:$bits(result_t)] !== '0)      s = {s, " padding"};
    return s;
  endfunction

  task automatic record_failure(input string msg);
    error_count++;
    if (error_count <= ReportLimit) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Observe all three channels mid-cycle. Inputs only move at the rising edge,
  // so what is seen here is exactly what the next edge will accept. Keep the
  // order: register writes, then input beats, then result beats.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : link_monitor
    result_t want;
    string   diffs;
    bit      any_beat;
    any_beat = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        any_beat = 1'b1;
        reg_writes++;
        case (cfg_index_i)
          REG_BREAK_PREFIX:    brk_code    = cfg_data_i;
          REG_EXTENDED_PREFIX: ext_code    = cfg_data_i;
          REG_MAX_RETRIES:     retry_limit = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        any_beat = 1'b1;
        results_due.push_back(predict_link_beat(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        any_beat = 1'b1;
        beats_checked++;
        if (results_due.size() == 0) begin
          record_failure($sformatf("result beat %h with nothing expected", m_axis_tdata));
        end else begin
          want  = results_due.pop_front();
          diffs = field_diffs(m_axis_tdata, want);
          if (diffs != "") begin
            record_failure($sformatf("beat %0d expected %h got %h, differs in:%s",
                                     beats_checked, {2'b00, want}, m_axis_tdata, diffs));
          end
          if (want.key_valid)       key_reports++;
          if (want.send_valid)      bytes_to_kbd++;
          if (want.queue_full_drop) refused_cmds++;
          if (want.retry_abandoned) dropped_cmds++;
        end
      end
    end
    idle_cycles = any_beat ? 0 : idle_cycles + 1;
  end

  // Stop a hung run: too long without any beat on any channel
  initial begin
    wait (idle_cycles >= StallLimit);
    $display("Watchdog: no beat for %0d cycles", StallLimit);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver side: stall at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one item; hold valid high afterwards so back-to-back beats need no gap.
  task automatic send_item(input logic kind, input logic [7:0] value);
    logic rdy;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // Write one register; drop valid before returning so calls can follow back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for every predicted beat, then let the ACK/RESEND
  // head-read path settle before touching registers.
  task automatic drain_link();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pacing(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain make, extended make, extended break under the reset prefixes
  task automatic test_scancodes();
    send_item(KIND_DEVICE_RX, 8'h1C);
    send_item(KIND_DEVICE_RX, EXTENDED_PREFIX_RST);
    send_item(KIND_DEVICE_RX, 8'h75);
    send_item(KIND_DEVICE_RX, EXTENDED_PREFIX_RST);
    send_item(KIND_DEVICE_RX, BREAK_PREFIX_RST);
    send_item(KIND_DEVICE_RX, 8'h75);
  endtask

  // Status bytes between a break prefix and its scancode must not clear it
  task automatic test_status_bytes();
    send_item(KIND_DEVICE_RX, BREAK_PREFIX_RST);
    send_item(KIND_DEVICE_RX, BYTE_OVERRUN);
    send_item(KIND_DEVICE_RX, BYTE_ERROR);
    send_item(KIND_DEVICE_RX, BYTE_BAT_OK);
    send_item(KIND_DEVICE_RX, BYTE_BAT_FAIL0);
    send_item(KIND_DEVICE_RX, BYTE_BAT_FAIL1);
    send_item(KIND_DEVICE_RX, BYTE_ECHO);
    send_item(KIND_DEVICE_RX, 8'h2B);
  endtask

  // Immediate send, queued send, resend of the head, ACK that empties the queue
  task automatic test_command_flow();
    send_item(KIND_HOST_CMD, 8'hFF);
    send_item(KIND_HOST_CMD, 8'h00);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
    send_item(KIND_DEVICE_RX, BYTE_ACK);
    send_item(KIND_DEVICE_RX, BYTE_ACK);
  endtask

  // Zero limit, resend on an empty queue at the limit, widest limit, and a
  // limit lowered below the running count
  task automatic test_retry_limits();
    drain_link();
    write_reg(REG_MAX_RETRIES, 8'h00);
    send_item(KIND_HOST_CMD, 8'hED);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
    drain_link();
    write_reg(REG_MAX_RETRIES, 8'hFF);      // upper bits are dropped: limit 15
    send_item(KIND_HOST_CMD, 8'hF4);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
    drain_link();
    write_reg(REG_MAX_RETRIES, 8'h01);
    send_item(KIND_DEVICE_RX, BYTE_RESEND);
  endtask

  // Equal prefixes, reserved bytes used as prefixes, unused register slot
  task automatic test_prefix_registers();
    drain_link();
    write_reg(REG_BREAK_PREFIX, 8'h12);
    write_reg(REG_EXTENDED_PREFIX, 8'h12);
    send_item(KIND_DEVICE_RX, 8'h12);
    send_item(KIND_DEVICE_RX, 8'h34);
    drain_link();
    write_reg(REG_BREAK_PREFIX, BYTE_ACK);
    write_reg(REG_EXTENDED_PREFIX, BYTE_RESEND);
    write_reg(REG_UNUSED, 8'h99);
    send_item(KIND_HOST_CMD, 8'h55);
    send_item(KIND_DEVICE_RX, BYTE_ACK);
  endtask

  // Mostly well-formed traffic: key sequences, command bursts that sometimes
  // overflow the queue, ACK/RESEND replies, and a share of raw noise.
  task automatic run_mixed_traffic(input int n_items);
    int         sent;
    int         pick;
    int         n;
    logic       kind;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        if ($urandom_range(0, 1)) begin
          send_item(KIND_DEVICE_RX, ext_code);
          sent++;
        end
        if ($urandom_range(0, 1)) begin
          send_item(KIND_DEVICE_RX, brk_code);
          sent++;
        end
        send_item(KIND_DEVICE_RX, 8'($urandom_range(0, 255)));
        sent++;
      end else if (pick < 55) begin
        // an occasional long burst pushes past the queue depth
        n = ($urandom_range(0, 7) == 0) ? QueueDepth + 3 : $urandom_range(1, 5);
        repeat (n) send_item(KIND_HOST_CMD, 8'($urandom_range(0, 255)));
        sent += n;
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(KIND_DEVICE_RX, ($urandom_range(0, 99) < 70) ? BYTE_ACK : BYTE_RESEND);
        end
        sent += n;
      end else begin
        kind = 1'($urandom_range(0, 1));
        b    = 8'($urandom_range(0, 255));
        send_item(kind, b);
        sent++;
      end
    end
  endtask

  // Four pacing mixes, each under its own register setting
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      drain_link();
      case (phase)
        0: begin
          set_pacing(0, 0);
          write_reg(REG_BREAK_PREFIX, BREAK_PREFIX_RST);
          write_reg(REG_EXTENDED_PREFIX, EXTENDED_PREFIX_RST);
          write_reg(REG_MAX_RETRIES, 8'(MAX_RETRIES_RST));
        end
        1: begin
          set_pacing(74, 0);
          write_reg(REG_BREAK_PREFIX, 8'h8C);
          write_reg(REG_EXTENDED_PREFIX, 8'h73);
          write_reg(REG_MAX_RETRIES, 8'h00);
        end
        2: begin
          set_pacing(0, 74);
          write_reg(REG_BREAK_PREFIX, 8'h12);
          write_reg(REG_EXTENDED_PREFIX, 8'h12);
          write_reg(REG_MAX_RETRIES, 8'h0F);
        end
        default: begin
          set_pacing(38, 38);
          write_reg(REG_BREAK_PREFIX, 8'($urandom_range(0, 255)));
          write_reg(REG_EXTENDED_PREFIX, 8'($urandom_range(0, 255)));
          write_reg(REG_MAX_RETRIES, 8'($urandom_range(1, 255)));
          write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        end
      endcase
      run_mixed_traffic(230);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_scancodes();
    test_status_bytes();
    test_command_flow();
    test_retry_limits();
    test_prefix_registers();
    test_random_traffic();

    // Let the last beats arrive, then let the pipeline settle before the final check
    drain_link();
    repeat (8) @(posedge clk_i);
    if (results_due.size() != 0) begin
      record_failure($sformatf("%0d expected beats never arrived", results_due.size()));
    end

    $display("Checked %0d result beats: %0d key events, %0d bytes to the keyboard, %0d refused",
             beats_checked, key_reports, bytes_to_kbd, refused_cmds);
    $display("and %0d abandoned commands, over %0d register writes and four pacing mixes; %0d errors",
             dropped_cmds, reg_writes, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
